@@ rtl/fet_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fet_pkg: shared types for the formula expression tokenizer
// Input item, output token and the token bundle passed through the queue.
// ----------------------------------------------------------------------------
package fet_pkg;

    // Width of every position field on the output token
    localparam int OUT_POS_W = 32;

    // Most tokens one input item can produce
    localparam int MAX_TOKENS = 3;

    // One input item
    typedef struct packed {
        logic [7:0] source_byte;
        logic       byte_valid;
        logic       end_of_source;
    } t_in_item;

    // One output token
    typedef struct packed {
        logic [4:0]           token_kind;
        logic [1:0]           error_code;
        logic [OUT_POS_W-1:0] start_offset;
        logic [OUT_POS_W-1:0] token_length;
        logic [OUT_POS_W-1:0] line_number;
        logic [OUT_POS_W-1:0] column_number;
        logic                 last_token;
    } t_token;

    // All tokens of one input item; slot 0 goes out first
    typedef struct packed {
        logic [1:0]                count;
        t_token [MAX_TOKENS-1:0]   tok;
    } t_bundle;

endpackage

@@ rtl/fet_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fet_fifo: small show-ahead queue
// Flop-based FIFO between the scanner and the token serializer. The head
// entry is visible on o_data whenever o_empty is low.
// ----------------------------------------------------------------------------
module fet_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    n_wr;
    logic [AW-1:0]    n_rd;

    // pointer wrap
    assign n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
    assign n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);

    assign o_data  = r_mem[r_rd];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ rtl/fet_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fet_front: byte scanner
// Takes one source byte per transfer, runs the lexer state machine and builds
// the bundle of tokens that the byte completes, with lengths and columns.
// ----------------------------------------------------------------------------
module fet_front #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  fet_pkg::t_in_item  i_item,
    input  logic               i_full,
    output logic               o_push,
    output fet_pkg::t_bundle   o_bundle
);

    localparam int PW = POSITION_WIDTH;
    localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};
    localparam logic [PW-1:0] POS_ONE = PW'(1);

    // token kinds
    localparam logic [4:0] KIND_PLUS    = 5'd0;
    localparam logic [4:0] KIND_MINUS   = 5'd1;
    localparam logic [4:0] KIND_STAR    = 5'd2;
    localparam logic [4:0] KIND_SLASH   = 5'd3;
    localparam logic [4:0] KIND_CARET   = 5'd4;
    localparam logic [4:0] KIND_PERCENT = 5'd5;
    localparam logic [4:0] KIND_LPAREN  = 5'd6;
    localparam logic [4:0] KIND_RPAREN  = 5'd7;
    localparam logic [4:0] KIND_COMMA   = 5'd8;
    localparam logic [4:0] KIND_SEMI    = 5'd9;
    localparam logic [4:0] KIND_ASSIGN  = 5'd10;
    localparam logic [4:0] KIND_NOT     = 5'd12;
    localparam logic [4:0] KIND_LT      = 5'd14;
    localparam logic [4:0] KIND_GT      = 5'd16;
    localparam logic [4:0] KIND_AND     = 5'd18;
    localparam logic [4:0] KIND_OR      = 5'd19;
    localparam logic [4:0] KIND_NUMBER  = 5'd20;
    localparam logic [4:0] KIND_IDENT   = 5'd21;
    localparam logic [4:0] KIND_LET     = 5'd22;
    localparam logic [4:0] KIND_VAR     = 5'd23;
    localparam logic [4:0] KIND_EOF     = 5'd24;
    localparam logic [4:0] KIND_ERROR   = 5'd25;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_EXPONENT   = 2'd2;

    // keyword tracker codes
    localparam logic [2:0] KW_NONE = 3'd0;
    localparam logic [2:0] KW_L    = 3'd1;
    localparam logic [2:0] KW_LE   = 3'd2;
    localparam logic [2:0] KW_LET  = 3'd3;
    localparam logic [2:0] KW_V    = 3'd4;
    localparam logic [2:0] KW_VA   = 3'd5;
    localparam logic [2:0] KW_VAR  = 3'd6;

    // characters
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UE      = 8'h45;
    localparam logic [7:0] CH_UZ      = 8'h5A;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_USCORE  = 8'h5F;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LE      = 8'h65;
    localparam logic [7:0] CH_LL      = 8'h6C;
    localparam logic [7:0] CH_LR      = 8'h72;
    localparam logic [7:0] CH_LT_T    = 8'h74;
    localparam logic [7:0] CH_LV      = 8'h76;
    localparam logic [7:0] CH_LZ      = 8'h7A;
    localparam logic [7:0] CH_BAR     = 8'h7C;

    typedef logic [PW-1:0] t_pos;

    typedef enum logic [3:0] {
        M_IDLE,
        M_OP,
        M_INT,
        M_DOTINT,
        M_FRAC,
        M_EXPE,
        M_EXPSIGN,
        M_EXPDIG,
        M_IDENT,
        M_LDOT
    } t_mode;

    // token before length and column are worked out
    typedef struct packed {
        logic [4:0] kind;
        logic [1:0] err;
        t_pos       start_pos;
        t_pos       end_pos;
        logic [1:0] fix_len;
        logic       use_span;
        logic       last;
        logic       new_line;
    } t_raw;

    // tokens produced by closing the token in progress
    typedef struct packed {
        logic [1:0] n;
        t_raw       t0;
        t_raw       t1;
        logic       stop;
    } t_fin;

    // effect of a byte seen between tokens
    typedef struct packed {
        logic       emit;
        t_raw       tok;
        t_mode      mode;
        logic [7:0] pend;
        t_pos       ts;
        logic [2:0] kw;
        t_pos       line;
        t_pos       lstart;
        logic       stop;
    } t_idl;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic t_pos sat_inc(input t_pos v);
        return (v == POS_MAX) ? v : v + POS_ONE;
    endfunction

    function automatic t_pos span(input t_pos a, input t_pos b);
        return (b > a) ? b - a : '0;
    endfunction

    function automatic logic [fet_pkg::OUT_POS_W-1:0] to_out(input t_pos v);
        logic [63:0] w;
        w = 64'(v);
        return w[fet_pkg::OUT_POS_W-1:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_0:CH_9]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]}) || (c == CH_USCORE);
    endfunction

    function automatic logic is_amp_bar(input logic [7:0] c);
        return (c == CH_AMP) || (c == CH_BAR);
    endfunction

    function automatic logic [4:0] op_base(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            CH_EQ:   k = KIND_ASSIGN;
            CH_BANG: k = KIND_NOT;
            CH_LT:   k = KIND_LT;
            CH_GT:   k = KIND_GT;
            CH_AMP:  k = KIND_AND;
            default: k = KIND_OR;
        endcase
        return k;
    endfunction

    // {hit, kind} for the one-character operators
    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] r;
        case (c)
            CH_PLUS:    r = {1'b1, KIND_PLUS};
            CH_MINUS:   r = {1'b1, KIND_MINUS};
            CH_STAR:    r = {1'b1, KIND_STAR};
            CH_SLASH:   r = {1'b1, KIND_SLASH};
            CH_CARET:   r = {1'b1, KIND_CARET};
            CH_PERCENT: r = {1'b1, KIND_PERCENT};
            CH_LPAREN:  r = {1'b1, KIND_LPAREN};
            CH_RPAREN:  r = {1'b1, KIND_RPAREN};
            CH_COMMA:   r = {1'b1, KIND_COMMA};
            CH_SEMI:    r = {1'b1, KIND_SEMI};
            default:    r = {1'b0, KIND_PLUS};
        endcase
        return r;
    endfunction

    function automatic t_raw mk_tok(input logic [4:0] kind, input logic [1:0] err,
                                    input t_pos s, input t_pos e, input logic [1:0] fl,
                                    input logic us, input logic last);
        t_raw t;
        t.kind      = kind;
        t.err       = err;
        t.start_pos = s;
        t.end_pos   = e;
        t.fix_len   = fl;
        t.use_span  = us;
        t.last      = last;
        t.new_line  = 1'b0;
        return t;
    endfunction

    // close the token in progress; e is the offset just past its last byte
    function automatic t_fin finish_tok(input t_mode m, input logic [7:0] pend,
                                        input t_pos ts, input logic [2:0] kw, input t_pos e);
        t_fin       f;
        t_pos       dot;
        logic [4:0] ik;
        f   = '0;
        dot = (e != '0) ? e - POS_ONE : '0;
        ik  = (kw == KW_LET) ? KIND_LET : (kw == KW_VAR) ? KIND_VAR : KIND_IDENT;
        case (m)
            M_OP: begin
                f.n = 2'd1;
                if (is_amp_bar(pend)) begin
                    f.t0   = mk_tok(KIND_ERROR, ERR_UNEXPECTED, ts, ts, 2'd1, 1'b0, 1'b1);
                    f.stop = 1'b1;
                end else begin
                    f.t0 = mk_tok(op_base(pend), ERR_NONE, ts, ts, 2'd1, 1'b0, 1'b0);
                end
            end
            M_INT, M_FRAC, M_EXPDIG: begin
                f.n  = 2'd1;
                f.t0 = mk_tok(KIND_NUMBER, ERR_NONE, ts, e, 2'd0, 1'b1, 1'b0);
            end
            M_DOTINT: begin
                // number, then the dot that had no digit after it
                f.n    = 2'd2;
                f.t0   = mk_tok(KIND_NUMBER, ERR_NONE, ts, dot, 2'd0, 1'b1, 1'b0);
                f.t1   = mk_tok(KIND_ERROR, ERR_UNEXPECTED, dot, dot, 2'd1, 1'b0, 1'b1);
                f.stop = 1'b1;
            end
            M_LDOT: begin
                f.n    = 2'd1;
                f.t0   = mk_tok(KIND_ERROR, ERR_UNEXPECTED, ts, ts, 2'd1, 1'b0, 1'b1);
                f.stop = 1'b1;
            end
            M_EXPE, M_EXPSIGN: begin
                f.n    = 2'd1;
                f.t0   = mk_tok(KIND_ERROR, ERR_EXPONENT, ts, e, 2'd0, 1'b1, 1'b1);
                f.stop = 1'b1;
            end
            M_IDENT: begin
                f.n  = 2'd1;
                f.t0 = mk_tok(ik, ERR_NONE, ts, e, 2'd0, 1'b1, 1'b0);
            end
            default: begin
            end
        endcase
        return f;
    endfunction

    // byte seen while no token is open
    function automatic t_idl idle_tok(input logic [7:0] c, input t_pos pos,
                                      input logic [7:0] pend, input t_pos ts,
                                      input logic [2:0] kw, input t_pos line,
                                      input t_pos lstart);
        t_idl       r;
        logic [5:0] sk;
        r.emit   = 1'b0;
        r.tok    = '0;
        r.mode   = M_IDLE;
        r.pend   = pend;
        r.ts     = ts;
        r.kw     = kw;
        r.line   = line;
        r.lstart = lstart;
        r.stop   = 1'b0;
        sk       = single_kind(c);
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
            r.emit = 1'b0;
        end else if (c == CH_NL) begin
            r.line   = sat_inc(line);
            r.lstart = sat_inc(pos);
        end else if (sk[5]) begin
            r.emit = 1'b1;
            r.tok  = mk_tok(sk[4:0], ERR_NONE, pos, pos, 2'd1, 1'b0, 1'b0);
        end else begin
            r.ts = pos;
            if (c inside {CH_EQ, CH_BANG, CH_LT, CH_GT, CH_AMP, CH_BAR}) begin
                r.pend = c;
                r.mode = M_OP;
            end else if (is_digit(c)) begin
                r.mode = M_INT;
            end else if (c == CH_DOT) begin
                r.mode = M_LDOT;
            end else if (is_alpha(c)) begin
                r.kw   = (c == CH_LL) ? KW_L : (c == CH_LV) ? KW_V : KW_NONE;
                r.mode = M_IDENT;
            end else begin
                r.emit = 1'b1;
                r.tok  = mk_tok(KIND_ERROR, ERR_UNEXPECTED, pos, pos, 2'd1, 1'b0, 1'b1);
                r.stop = 1'b1;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_mode      r_mode,    n_mode;
    logic [7:0] r_pend,    n_pend;
    t_pos       r_off,     n_off;
    t_pos       r_off_inc, n_off_inc;
    t_pos       r_ts,      n_ts;
    t_pos       r_line,    n_line;
    t_pos       r_lstart,  n_lstart;
    logic [2:0] r_kw,      n_kw;
    logic       r_stopped, n_stopped;

    logic       accept;
    logic [1:0] cnt;
    t_raw       slot [fet_pkg::MAX_TOKENS];

    assign accept = i_valid && !i_full;

    // next state and token slots for the byte on the input
    always_comb begin
        logic [7:0] c;
        logic [7:0] second;
        logic       keep;
        logic       do_idle;
        t_fin       fin;
        t_fin       fin_eof;
        t_idl       idl;
        c          = i_item.source_byte;
        second     = CH_EQ;
        keep       = 1'b0;
        do_idle    = 1'b0;
        fin        = '0;
        fin_eof    = '0;
        idl        = '0;
        n_mode     = r_mode;
        n_pend     = r_pend;
        n_off      = r_off;
        n_off_inc  = r_off_inc;
        n_ts       = r_ts;
        n_line     = r_line;
        n_lstart   = r_lstart;
        n_kw       = r_kw;
        n_stopped  = r_stopped;
        cnt        = 2'd0;
        for (int i = 0; i < fet_pkg::MAX_TOKENS; i++) begin
            slot[i] = '0;
        end

        if (!r_stopped) begin
            if (i_item.byte_valid) begin
                // extend the open token if the byte fits it
                case (r_mode)
                    M_OP: begin
                        second = is_amp_bar(r_pend) ? r_pend : CH_EQ;
                        if (c == second) begin
                            slot[cnt] = mk_tok(op_base(r_pend)
                                               + (is_amp_bar(r_pend) ? 5'd0 : 5'd1),
                                               ERR_NONE, r_ts, r_ts, 2'd2, 1'b0, 1'b0);
                            cnt    = cnt + 2'd1;
                            n_mode = M_IDLE;
                            keep   = 1'b1;
                        end
                    end
                    M_INT: begin
                        if (is_digit(c)) begin
                            keep = 1'b1;
                        end else if (c == CH_DOT) begin
                            n_mode = M_DOTINT;
                            keep   = 1'b1;
                        end else if (c == CH_LE || c == CH_UE) begin
                            n_mode = M_EXPE;
                            keep   = 1'b1;
                        end
                    end
                    M_DOTINT, M_LDOT: begin
                        if (is_digit(c)) begin
                            n_mode = M_FRAC;
                            keep   = 1'b1;
                        end
                    end
                    M_FRAC: begin
                        if (is_digit(c)) begin
                            keep = 1'b1;
                        end else if (c == CH_LE || c == CH_UE) begin
                            n_mode = M_EXPE;
                            keep   = 1'b1;
                        end
                    end
                    M_EXPE: begin
                        if (c == CH_PLUS || c == CH_MINUS) begin
                            n_mode = M_EXPSIGN;
                            keep   = 1'b1;
                        end else if (is_digit(c)) begin
                            n_mode = M_EXPDIG;
                            keep   = 1'b1;
                        end
                    end
                    M_EXPSIGN: begin
                        if (is_digit(c)) begin
                            n_mode = M_EXPDIG;
                            keep   = 1'b1;
                        end
                    end
                    M_EXPDIG: begin
                        if (is_digit(c)) begin
                            keep = 1'b1;
                        end
                    end
                    M_IDENT: begin
                        if (is_alpha(c) || is_digit(c)) begin
                            if (r_kw == KW_L && c == CH_LE) begin
                                n_kw = KW_LE;
                            end else if (r_kw == KW_LE && c == CH_LT_T) begin
                                n_kw = KW_LET;
                            end else if (r_kw == KW_V && c == CH_LA) begin
                                n_kw = KW_VA;
                            end else if (r_kw == KW_VA && c == CH_LR) begin
                                n_kw = KW_VAR;
                            end else begin
                                n_kw = KW_NONE;
                            end
                            keep = 1'b1;
                        end
                    end
                    default: begin
                        n_mode  = M_IDLE;
                        do_idle = 1'b1;
                        keep    = 1'b1;
                    end
                endcase

                // byte does not fit: close the token, then rescan the byte
                if (!keep) begin
                    fin    = finish_tok(r_mode, r_pend, r_ts, r_kw, r_off);
                    n_mode = M_IDLE;
                    if (fin.n != 2'd0) begin
                        slot[cnt] = fin.t0;
                        cnt       = cnt + 2'd1;
                    end
                    if (fin.n == 2'd2) begin
                        slot[cnt] = fin.t1;
                        cnt       = cnt + 2'd1;
                    end
                    if (fin.stop) begin
                        n_stopped = 1'b1;
                    end else begin
                        do_idle = 1'b1;
                    end
                end

                if (do_idle) begin
                    idl      = idle_tok(c, r_off, n_pend, n_ts, n_kw, n_line, n_lstart);
                    n_mode   = idl.mode;
                    n_pend   = idl.pend;
                    n_ts     = idl.ts;
                    n_kw     = idl.kw;
                    n_line   = idl.line;
                    n_lstart = idl.lstart;
                    if (idl.stop) begin
                        n_stopped = 1'b1;
                    end
                    if (idl.emit) begin
                        slot[cnt] = idl.tok;
                        cnt       = cnt + 2'd1;
                    end
                end

                n_off     = r_off_inc;
                n_off_inc = sat_inc(r_off_inc);
            end

            // end of source: close any open token, then end-of-file
            if (i_item.end_of_source && !n_stopped) begin
                fin_eof = finish_tok(n_mode, n_pend, n_ts, n_kw, n_off);
                if (fin_eof.n != 2'd0) begin
                    slot[cnt] = fin_eof.t0;
                    cnt       = cnt + 2'd1;
                end
                if (fin_eof.n == 2'd2) begin
                    slot[cnt] = fin_eof.t1;
                    cnt       = cnt + 2'd1;
                end
                if (!fin_eof.stop) begin
                    slot[cnt] = mk_tok(KIND_EOF, ERR_NONE, n_off, n_off, 2'd0, 1'b0, 1'b1);
                    slot[cnt].new_line = 1'b1;
                    cnt       = cnt + 2'd1;
                end
                n_stopped = 1'b1;
                n_mode    = M_IDLE;
            end
        end
    end

    // length, line and column for each slot
    always_comb begin
        t_pos ls;
        t_pos ln;
        t_pos len;
        t_pos col;
        ls = '0;
        ln = '0;
        len = '0;
        col = '0;
        o_bundle.count = cnt;
        for (int i = 0; i < fet_pkg::MAX_TOKENS; i++) begin
            ls  = slot[i].new_line ? n_lstart : r_lstart;
            ln  = slot[i].new_line ? n_line : r_line;
            len = slot[i].use_span ? span(slot[i].start_pos, slot[i].end_pos)
                                   : PW'(slot[i].fix_len);
            col = sat_inc(span(ls, slot[i].start_pos));
            o_bundle.tok[i].token_kind    = slot[i].kind;
            o_bundle.tok[i].error_code    = slot[i].err;
            o_bundle.tok[i].start_offset  = to_out(slot[i].start_pos);
            o_bundle.tok[i].token_length  = to_out(len);
            o_bundle.tok[i].line_number   = to_out(ln);
            o_bundle.tok[i].column_number = to_out(col);
            o_bundle.tok[i].last_token    = slot[i].last;
        end
    end

    assign o_push = accept && (cnt != 2'd0);

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_IDLE;
            r_pend    <= '0;
            r_off     <= '0;
            r_off_inc <= POS_ONE;
            r_ts      <= '0;
            r_line    <= POS_ONE;
            r_lstart  <= '0;
            r_kw      <= KW_NONE;
            r_stopped <= 1'b0;
        end else if (accept) begin
            r_mode    <= n_mode;
            r_pend    <= n_pend;
            r_off     <= n_off;
            r_off_inc <= n_off_inc;
            r_ts      <= n_ts;
            r_line    <= n_line;
            r_lstart  <= n_lstart;
            r_kw      <= n_kw;
            r_stopped <= n_stopped;
        end
    end

endmodule

@@ rtl/fet_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fet_back: token serializer
// Reads bundles from the queue head and sends their tokens one per transfer
// through a registered output stage.
// ----------------------------------------------------------------------------
module fet_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fet_pkg::t_bundle  i_head,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output fet_pkg::t_token   o_token
);

    logic            r_valid;
    logic [1:0]      r_idx;
    fet_pkg::t_token r_tok;
    logic            load;
    logic            last_in_bundle;

    // output stage can take a token when empty or being drained
    assign load           = !i_empty && (!r_valid || !i_stall);
    assign last_in_bundle = ((r_idx + 2'd1) == i_head.count);
    assign o_pop          = load && last_in_bundle;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last_in_bundle ? 2'd0 : r_idx + 2'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tok <= i_head.tok[r_idx];
        end
    end

    assign o_valid = r_valid;
    assign o_token = r_tok;

endmodule

@@ rtl/formula_expression_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// formula_expression_tokenizer: streaming lexer for a small formula language
// Source bytes in, tokens (kind, offset, length, line, column) out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall / i_item): one source byte per transfer;
//   byte_valid low gives an empty item, end_of_source marks the last item.
//   Output channel (o_valid / i_stall / o_token): one token per transfer.
//   The scanner takes one byte per cycle while o_stall is low; each item
//   yields zero to three tokens. A token passes the bundle queue and the
//   registered output stage before it shows on o_valid. Tokens leave one per
//   cycle while i_stall is low; a bundle leaves the queue with its last token.
//   A queue of QUEUE_DEPTH bundles sits between scanner and output stage;
//   when the receiver stalls, the queue fills and o_stall rises once it is
//   full. o_stall depends only on the queue fill, never on i_valid.
//   After an error or end-of-file token (last_token high) all further input
//   is taken and dropped until reset. Reset is synchronous: the scanner
//   returns to line 1, offset 0, and queue and output stage are emptied.
//   Positions saturate at 2**POSITION_WIDTH-1.
// ----------------------------------------------------------------------------
module formula_expression_tokenizer #(
    parameter int POSITION_WIDTH = 32,
    parameter int QUEUE_DEPTH    = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  fet_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_stall,
    output fet_pkg::t_token   o_token
);

    localparam int BUNDLE_W = $bits(fet_pkg::t_bundle);

    fet_pkg::t_bundle push_bundle;
    fet_pkg::t_bundle head_bundle;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;

    // scanner
    fet_front #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_item   (i_item),
        .i_full   (full),
        .o_push   (push),
        .o_bundle (push_bundle)
    );

    // bundle queue
    fet_fifo #(
        .WIDTH (BUNDLE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_bundle),
        .i_pop   (pop),
        .o_data  (head_bundle),
        .o_full  (full),
        .o_empty (empty)
    );

    // token serializer and output stage
    fet_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_bundle),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_token (o_token)
    );

    assign o_stall = full;

endmodule

@@ verif/formula_expression_tokenizer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// formula_expression_tokenizer_tb: self-checking bench for the tokenizer
// Feeds one source text made of directed and random well-formed tokens,
// closed by one terminating case (end-of-file or an error), then some
// ignored items. A local lexer predicts every token, and the monitor
// compares each output transfer field by field with the oldest prediction.
// Both sides idle at random, and the receiver holds off once for a long
// stretch so that the internal queue fills and the input stalls.
// ----------------------------------------------------------------------------
module formula_expression_tokenizer_tb;
    import fet_pkg::*;

    // Token kinds
    localparam logic [4:0] KIND_PLUS   = 5'd0;
    localparam logic [4:0] KIND_MINUS  = 5'd1;
    localparam logic [4:0] KIND_STAR   = 5'd2;
    localparam logic [4:0] KIND_SLASH  = 5'd3;
    localparam logic [4:0] KIND_CARET  = 5'd4;
    localparam logic [4:0] KIND_PCT    = 5'd5;
    localparam logic [4:0] KIND_LPAREN = 5'd6;
    localparam logic [4:0] KIND_RPAREN = 5'd7;
    localparam logic [4:0] KIND_COMMA  = 5'd8;
    localparam logic [4:0] KIND_SEMI   = 5'd9;
    localparam logic [4:0] KIND_ASSIGN = 5'd10;
    localparam logic [4:0] KIND_NOT    = 5'd12;
    localparam logic [4:0] KIND_LT     = 5'd14;
    localparam logic [4:0] KIND_GT     = 5'd16;
    localparam logic [4:0] KIND_AND    = 5'd18;
    localparam logic [4:0] KIND_OR     = 5'd19;
    localparam logic [4:0] KIND_NUMBER = 5'd20;
    localparam logic [4:0] KIND_IDENT  = 5'd21;
    localparam logic [4:0] KIND_LET    = 5'd22;
    localparam logic [4:0] KIND_VAR    = 5'd23;
    localparam logic [4:0] KIND_EOF    = 5'd24;
    localparam logic [4:0] KIND_ERROR  = 5'd25;

    // Error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_EXPONENT   = 2'd2;

    // Keyword tracking while inside an identifier
    localparam logic [3:0] KW_NONE = 4'd0;
    localparam logic [3:0] KW_L    = 4'd1;
    localparam logic [3:0] KW_LE   = 4'd2;
    localparam logic [3:0] KW_LET  = 4'd3;
    localparam logic [3:0] KW_V    = 4'd4;
    localparam logic [3:0] KW_VA   = 4'd5;
    localparam logic [3:0] KW_VAR  = 4'd6;

    // Whitespace bytes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [31:0] POS_MAX = '1;

    localparam int RANDOM_ITEMS  = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_TRIGGER  = 40;
    localparam int DRAIN_CYCLES  = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SHOWN_ERRORS  = 10;

    typedef enum logic [3:0] {
        SCAN_IDLE, SCAN_OP, SCAN_INT, SCAN_DOTINT, SCAN_FRAC,
        SCAN_EXPE, SCAN_EXPSIGN, SCAN_EXPDIG, SCAN_IDENT, SCAN_LDOT
    } scan_e;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     in_valid = 1'b0;
    t_in_item in_item = '0;
    logic     out_stall = 1'b0;
    logic     dut_stall;
    logic     dut_valid;
    t_token   dut_token;

    formula_expression_tokenizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_stall (dut_stall),
        .i_item  (in_item),
        .o_valid (dut_valid),
        .i_stall (out_stall),
        .o_token (dut_token)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    t_in_item items_pending[$];
    t_token   tokens_due[$];
    int       source_items = 0;
    int       cycle_count = 0;
    int       tokens_seen = 0;
    int       mismatch_count = 0;
    int       gap_left = 0;
    int       stall_left = 0;
    bit       hold_done = 1'b0;
    t_token   want;

    string ID_FIRST = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string ID_REST  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string OP_CHARS = "+-*/^%(),;=!<>";
    string ODD_CHARS = "@#$?~`'\"[]{}:\\";

    // Lexer state of the predictor; reset values
    scan_e       lex_mode = SCAN_IDLE;
    logic [7:0]  lex_pending = 8'h00;
    logic [31:0] lex_offset = '0;
    logic [31:0] lex_start = '0;
    logic [31:0] lex_line = 32'd1;
    logic [31:0] lex_line_start = '0;
    logic [3:0]  lex_kw = KW_NONE;
    bit          lex_stopped = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] pos_inc(logic [31:0] v);
        return (v == POS_MAX) ? v : v + 32'd1;
    endfunction

    function automatic logic [31:0] pos_span(logic [31:0] a, logic [31:0] b);
        return (b > a) ? b - a : 32'd0;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_amp_bar(logic [7:0] c);
        return c == "&" || c == "|";
    endfunction

    function automatic logic [4:0] pair_base(logic [7:0] c);
        case (c)
            "=": return KIND_ASSIGN;
            "!": return KIND_NOT;
            "<": return KIND_LT;
            ">": return KIND_GT;
            "&": return KIND_AND;
            default: return KIND_OR;
        endcase
    endfunction

    // Kind of a one-character operator, or -1
    function automatic int single_kind(logic [7:0] c);
        case (c)
            "+": return KIND_PLUS;
            "-": return KIND_MINUS;
            "*": return KIND_STAR;
            "/": return KIND_SLASH;
            "^": return KIND_CARET;
            "%": return KIND_PCT;
            "(": return KIND_LPAREN;
            ")": return KIND_RPAREN;
            ",": return KIND_COMMA;
            ";": return KIND_SEMI;
            default: return -1;
        endcase
    endfunction

    function automatic void push_token(logic [4:0] kind, logic [1:0] err,
                                       logic [31:0] start, logic [31:0] len, logic last);
        t_token t;
        t.token_kind    = kind;
        t.error_code    = err;
        t.start_offset  = start;
        t.token_length  = len;
        t.line_number   = lex_line;
        t.column_number = pos_inc(pos_span(lex_line_start, start));
        t.last_token    = last;
        tokens_due.push_back(t);
    endfunction

    function automatic void lex_stop(logic [1:0] err, logic [31:0] start, logic [31:0] len);
        push_token(KIND_ERROR, err, start, len, 1'b1);
        lex_stopped = 1'b1;
        lex_mode    = SCAN_IDLE;
    endfunction

    // Close the token in progress; end_pos is just past its last byte
    function automatic void lex_close(logic [31:0] end_pos);
        scan_e       m;
        logic [31:0] dot;
        m = lex_mode;
        lex_mode = SCAN_IDLE;
        case (m)
            SCAN_OP: begin
                if (is_amp_bar(lex_pending)) lex_stop(ERR_UNEXPECTED, lex_start, 32'd1);
                else push_token(pair_base(lex_pending), ERR_NONE, lex_start, 32'd1, 1'b0);
            end
            SCAN_INT, SCAN_FRAC, SCAN_EXPDIG: begin
                push_token(KIND_NUMBER, ERR_NONE, lex_start, pos_span(lex_start, end_pos), 1'b0);
            end
            SCAN_DOTINT: begin
                // digits then a dot with no fraction: number, then error at the dot
                dot = (end_pos > 0) ? end_pos - 32'd1 : 32'd0;
                push_token(KIND_NUMBER, ERR_NONE, lex_start, pos_span(lex_start, dot), 1'b0);
                lex_stop(ERR_UNEXPECTED, dot, 32'd1);
            end
            SCAN_LDOT: lex_stop(ERR_UNEXPECTED, lex_start, 32'd1);
            SCAN_EXPE, SCAN_EXPSIGN: begin
                lex_stop(ERR_EXPONENT, lex_start, pos_span(lex_start, end_pos));
            end
            SCAN_IDENT: begin
                push_token(lex_kw == KW_LET ? KIND_LET : lex_kw == KW_VAR ? KIND_VAR : KIND_IDENT,
                           ERR_NONE, lex_start, pos_span(lex_start, end_pos), 1'b0);
            end
            default: ;
        endcase
    endfunction

    // Byte seen between tokens
    function automatic void lex_idle(logic [7:0] c, logic [31:0] pos);
        int k;
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR) return;
        if (c == CH_LF) begin
            lex_line       = pos_inc(lex_line);
            lex_line_start = pos_inc(pos);
            return;
        end
        k = single_kind(c);
        if (k >= 0) begin
            push_token(5'(k), ERR_NONE, pos, 32'd1, 1'b0);
            return;
        end
        lex_start = pos;
        if (c == "=" || c == "!" || c == "<" || c == ">" || is_amp_bar(c)) begin
            lex_pending = c;
            lex_mode    = SCAN_OP;
        end else if (is_digit(c)) begin
            lex_mode = SCAN_INT;
        end else if (c == ".") begin
            lex_mode = SCAN_LDOT;
        end else if (is_letter(c)) begin
            lex_kw   = (c == "l") ? KW_L : (c == "v") ? KW_V : KW_NONE;
            lex_mode = SCAN_IDENT;
        end else begin
            lex_stop(ERR_UNEXPECTED, pos, 32'd1);
        end
    endfunction

    function automatic void lex_take(logic [7:0] c);
        logic [31:0] pos;
        logic [7:0]  second;
        bit          keep;
        pos  = lex_offset;
        keep = 1'b0;
        case (lex_mode)
            SCAN_OP: begin
                second = is_amp_bar(lex_pending) ? lex_pending : "=";
                if (c == second) begin
                    push_token(pair_base(lex_pending) + (is_amp_bar(lex_pending) ? 5'd0 : 5'd1),
                               ERR_NONE, lex_start, 32'd2, 1'b0);
                    lex_mode = SCAN_IDLE;
                    keep     = 1'b1;
                end
            end
            SCAN_INT: begin
                if (is_digit(c)) keep = 1'b1;
                else if (c == ".") begin lex_mode = SCAN_DOTINT; keep = 1'b1; end
                else if (c == "e" || c == "E") begin lex_mode = SCAN_EXPE; keep = 1'b1; end
            end
            SCAN_DOTINT, SCAN_LDOT: begin
                if (is_digit(c)) begin lex_mode = SCAN_FRAC; keep = 1'b1; end
            end
            SCAN_FRAC: begin
                if (is_digit(c)) keep = 1'b1;
                else if (c == "e" || c == "E") begin lex_mode = SCAN_EXPE; keep = 1'b1; end
            end
            SCAN_EXPE: begin
                if (c == "+" || c == "-") begin lex_mode = SCAN_EXPSIGN; keep = 1'b1; end
                else if (is_digit(c)) begin lex_mode = SCAN_EXPDIG; keep = 1'b1; end
            end
            SCAN_EXPSIGN: begin
                if (is_digit(c)) begin lex_mode = SCAN_EXPDIG; keep = 1'b1; end
            end
            SCAN_EXPDIG: begin
                if (is_digit(c)) keep = 1'b1;
            end
            SCAN_IDENT: begin
                if (is_letter(c) || is_digit(c)) begin
                    if (lex_kw == KW_L && c == "e") lex_kw = KW_LE;
                    else if (lex_kw == KW_LE && c == "t") lex_kw = KW_LET;
                    else if (lex_kw == KW_V && c == "a") lex_kw = KW_VA;
                    else if (lex_kw == KW_VA && c == "r") lex_kw = KW_VAR;
                    else lex_kw = KW_NONE;
                    keep = 1'b1;
                end
            end
            default: begin
                lex_mode = SCAN_IDLE;
                lex_idle(c, pos);
                keep = 1'b1;
            end
        endcase
        if (!keep) begin
            lex_close(pos);
            if (!lex_stopped) lex_idle(c, pos);
        end
        lex_offset = pos_inc(lex_offset);
    endfunction

    // Expected tokens of one accepted input item
    function automatic void predict_tokens(t_in_item it);
        if (lex_stopped) return;
        if (it.byte_valid) lex_take(it.source_byte);
        if (it.end_of_source && !lex_stopped) begin
            lex_close(lex_offset);
            if (!lex_stopped) push_token(KIND_EOF, ERR_NONE, lex_offset, 32'd0, 1'b1);
            lex_stopped = 1'b1;
            lex_mode    = SCAN_IDLE;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_char(input logic [7:0] c);
        items_pending.push_back('{source_byte: c, byte_valid: 1'b1, end_of_source: 1'b0});
        source_items++;
    endtask

    // Item without a character; the byte lines carry random junk
    task automatic push_empty();
        items_pending.push_back('{source_byte: 8'($urandom), byte_valid: 1'b0,
                                  end_of_source: 1'b0});
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endtask

    task automatic push_digits(input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) push_char(8'("0" + $urandom_range(0, 9)));
    endtask

    task automatic add_number();
        int r;
        if ($urandom_range(0, 5) == 0) begin
            push_char(".");
            push_digits(1, 3);
        end else begin
            push_digits(1, 4);
            if ($urandom_range(0, 2) == 0) begin
                push_char(".");
                push_digits(1, 3);
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            push_char($urandom_range(0, 1) ? "e" : "E");
            r = $urandom_range(0, 2);
            if (r == 1) push_char("+");
            else if (r == 2) push_char("-");
            push_digits(1, 2);
        end
    endtask

    task automatic add_ident();
        case ($urandom_range(0, 11))
            0: push_text("let");
            1: push_text("var");
            2: push_text("le");
            3: push_text("va");
            4: push_text("lets");
            5: push_text("var_");
            default: begin
                push_char(ID_FIRST[$urandom_range(0, ID_FIRST.len() - 1)]);
                repeat ($urandom_range(0, 5)) push_char(ID_REST[$urandom_range(0, ID_REST.len() - 1)]);
            end
        endcase
    endtask

    task automatic add_operator();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            14: push_text("==");
            15: push_text("!=");
            16: push_text("<=");
            17: push_text(">=");
            18: push_text("&&");
            19: push_text("||");
            default: push_char(OP_CHARS[r]);
        endcase
    endtask

    task automatic add_blank();
        repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 5))
                0: push_char(CH_TAB);
                1: push_char(CH_CR);
                2: push_char(CH_LF);
                default: push_char(CH_SPACE);
            endcase
        end
    endtask

    // One terminating case: end-of-file or one of the error cases
    task automatic add_terminator();
        logic bv;
        push_char(CH_SPACE);
        case ($urandom_range(0, 7))
            0: ;
            1: push_text("9.");
            2: push_text($urandom_range(0, 1) ? ".a" : ".");
            3: push_text($urandom_range(0, 1) ? "4e+" : "31E");
            4: push_text("&a");
            5: push_text("|;");
            6: begin
                if ($urandom_range(0, 1)) push_char(8'($urandom_range(128, 255)));
                else push_char(ODD_CHARS[$urandom_range(0, ODD_CHARS.len() - 1)]);
            end
            default: push_char(8'h00);
        endcase
        bv = 1'($urandom_range(0, 1));
        items_pending.push_back('{source_byte: bv ? "x" : 8'($urandom), byte_valid: bv,
                                  end_of_source: 1'b1});
        source_items++;
        // everything after this is dropped by the block
        repeat (12) items_pending.push_back(t_in_item'(10'($urandom)));
    endtask

    function automatic int pick_gap();
        int r;
        // quiet windows with no idling at all
        if (cycle_count[9:8] == 2'b00) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Input driver: one transfer per accepted item
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_item  <= '0;
            gap_left <= 0;
        end else begin
            if (in_valid && !dut_stall) predict_tokens(in_item);
            if (!in_valid || !dut_stall) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (items_pending.size() != 0) begin
                    in_item  <= items_pending.pop_front();
                    in_valid <= 1'b1;
                    gap_left <= pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stall: random idling plus one long hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!hold_done && tokens_seen >= HOLD_TRIGGER) begin
            out_stall  <= 1'b1;
            stall_left <= HOLD_CYCLES;
            hold_done  <= 1'b1;
        end else if (out_stall) begin
            out_stall <= 1'b0;
        end else begin
            stall_left <= pick_gap();
            out_stall  <= (pick_gap() != 0);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare every output transfer with the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string field, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_ERRORS)
                $display("token %0d %s: expected %0d, got %0d", tokens_seen, field, exp_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && dut_valid === 1'b1 && !out_stall) begin
            tokens_seen <= tokens_seen + 1;
            if (tokens_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOWN_ERRORS)
                    $display("token %0d: none expected, got kind %0d at offset %0d",
                             tokens_seen, dut_token.token_kind, dut_token.start_offset);
            end else begin
                want = tokens_due.pop_front();
                check_field("kind",   32'(want.token_kind),   32'(dut_token.token_kind));
                check_field("error",  32'(want.error_code),   32'(dut_token.error_code));
                check_field("start",  want.start_offset,      dut_token.start_offset);
                check_field("length", want.token_length,      dut_token.token_length);
                check_field("line",   want.line_number,       dut_token.line_number);
                check_field("column", want.column_number,     dut_token.column_number);
                check_field("last",   32'(want.last_token),   32'(dut_token.last_token));
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int k;
        int random_end;
        bit after_number;

        // directed: keywords, every operator, whitespace, number forms
        push_text("let var lets _x9 Q=1;\n");
        push_text("+-*/^%(),;==!=<=>=&&||=!<>");
        push_char(CH_TAB);
        push_char(CH_CR);
        push_text(" 0.5e+1 .25 7E-3 42e9 ");
        push_empty();

        // random well-formed tokens
        random_end   = source_items + RANDOM_ITEMS;
        after_number = 1'b0;
        while (source_items < random_end) begin
            k = $urandom_range(0, 99);
            if (k < 30) begin
                // keeps "1" + "e.." from reading as an exponent
                if (after_number) add_blank();
                add_ident();
                after_number = 1'b0;
            end else if (k < 55) begin
                if (after_number) add_blank();
                add_number();
                after_number = 1'b1;
            end else if (k < 80) begin
                add_operator();
                after_number = 1'b0;
            end else if (k < 95) begin
                add_blank();
                after_number = 1'b0;
            end else begin
                repeat ($urandom_range(1, 3)) push_empty();
            end
        end
        add_terminator();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_pending.size() != 0 || in_valid) @(posedge i_clk);
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && tokens_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/fet_pkg.sv
rtl/fet_fifo.sv
rtl/fet_front.sv
rtl/fet_back.sv
rtl/formula_expression_tokenizer.sv
verif/formula_expression_tokenizer_tb.sv
